// ----- hw/rtl/lfc_pkg.sv -----
// shared types, constants and crc function for the link frame checker
`default_nettype none
package lfc_pkg;
  localparam int unsigned HdrLen = 36;
  localparam logic [31:0] FrameMagic = 32'h4c445341;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_MAGIC = 3'd2;
  localparam logic [2:0] ST_HSIZE = 3'd3;
  localparam logic [2:0] ST_LENGTH = 3'd4;
  localparam logic [2:0] ST_HCRC = 3'd5;
  localparam logic [2:0] ST_PCRC = 3'd6;

  // one classified transaction from the front end
  typedef struct packed {
    logic       pass;
    logic [7:0] data;
    logic       verdict;
    logic [2:0] status;
  } lfc_cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/lfc_front.sv -----
// front end: header capture, crc tracking and classification of each byte
`default_nettype none
module lfc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       data_byte,
  input  wire logic             end_of_buffer,
  output lfc_pkg::lfc_cmd_t     cmd,
  output logic [7:0]            version,
  output logic [15:0]           flag_bits,
  output logic [31:0]           link_seq,
  output logic [31:0]           total_size,
  output logic [31:0]           frag_offset,
  output logic [15:0]           frag_index,
  output logic [15:0]           frag_count
);
  logic [5:0]  header_pos;
  logic [32:0] payload_seen;
  logic [7:0]  header_store [lfc_pkg::HdrLen];
  logic [31:0] hdr_crc_run, pay_crc_run;
  logic        header_good;
  logic        in_hdr;
  logic [31:0] hcrc_next, pcrc_next, magic, paylen, pcrc_want, hcrc_want;
  logic [32:0] seen_next;
  logic [5:0]  pos_next;
  logic        magic_ok, hsize_ok, hcrc_ok;

  assign in_hdr = header_pos < 6'(lfc_pkg::HdrLen);
  assign pos_next = header_pos + 6'd1;
  assign hcrc_next = lfc_pkg::crc_byte(hdr_crc_run, (header_pos >= 6'd32) ? 8'd0 : data_byte);
  assign pcrc_next = lfc_pkg::crc_byte(pay_crc_run, data_byte);
  assign seen_next = (payload_seen != '1) ? payload_seen + 33'd1 : payload_seen;
  assign magic = {header_store[3], header_store[2], header_store[1], header_store[0]};
  assign paylen = {header_store[23], header_store[22], header_store[21], header_store[20]};
  assign pcrc_want = {header_store[31], header_store[30], header_store[29], header_store[28]};
  assign hcrc_want = {header_store[35], header_store[34], header_store[33], header_store[32]};
  assign magic_ok = magic == lfc_pkg::FrameMagic;
  assign hsize_ok = header_store[5] == 8'(lfc_pkg::HdrLen);
  assign hcrc_ok = ~hdr_crc_run == hcrc_want;
  assign version = header_store[4];
  assign flag_bits = {header_store[7], header_store[6]};
  assign link_seq = {header_store[11], header_store[10], header_store[9], header_store[8]};
  assign total_size = {header_store[15], header_store[14], header_store[13], header_store[12]};
  assign frag_offset = {header_store[19], header_store[18], header_store[17], header_store[16]};
  assign frag_index = {header_store[25], header_store[24]};
  assign frag_count = {header_store[27], header_store[26]};

  // good flag uses the incoming last header byte directly
  logic [31:0] want_final;
  assign want_final = {data_byte, header_store[34], header_store[33], header_store[32]};

  // a frame may close on its final header byte, before any payload
  logic        hdr_last;
  logic [32:0] seen_chk;
  logic        hcrc_chk;
  logic [31:0] pcrc_chk;
  assign hdr_last = header_pos == 6'(lfc_pkg::HdrLen - 1);
  assign seen_chk = in_hdr ? payload_seen : seen_next;
  assign hcrc_chk = in_hdr ? (~hcrc_next == want_final) : hcrc_ok;
  assign pcrc_chk = in_hdr ? ~pay_crc_run : ~pcrc_next;

  // frame checks for the byte closing a frame: short buffer, header, length and crcs
  logic [2:0] st;
  always_comb begin
    if (in_hdr && !hdr_last) st = lfc_pkg::ST_SHORT;
    else if (!magic_ok) st = lfc_pkg::ST_MAGIC;
    else if (!hsize_ok) st = lfc_pkg::ST_HSIZE;
    else if (seen_chk != {1'b0, paylen}) st = lfc_pkg::ST_LENGTH;
    else if (!hcrc_chk) st = lfc_pkg::ST_HCRC;
    else if (pcrc_chk != pcrc_want) st = lfc_pkg::ST_PCRC;
    else st = lfc_pkg::ST_OK;
  end

  assign cmd.pass = !in_hdr && header_good;
  assign cmd.data = data_byte;
  assign cmd.verdict = end_of_buffer;
  assign cmd.status = st;

  always_ff @(posedge clk) begin
    if (take && in_hdr) begin
      header_store[header_pos] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos <= '0;
      payload_seen <= '0;
      hdr_crc_run <= '1;
      pay_crc_run <= '1;
      header_good <= 1'b0;
    end else if (take) begin
      if (end_of_buffer) begin
        header_pos <= '0;
        payload_seen <= '0;
        hdr_crc_run <= '1;
        pay_crc_run <= '1;
        header_good <= 1'b0;
      end else if (in_hdr) begin
        header_pos <= pos_next;
        hdr_crc_run <= hcrc_next;
        if (pos_next == 6'(lfc_pkg::HdrLen)) begin
          header_good <= magic_ok && hsize_ok && (~hcrc_next == want_final);
        end
      end else begin
        payload_seen <= seen_next;
        pay_crc_run <= pcrc_next;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) header_good |-> !in_hdr)
    else $error("good header flag set during header capture");
  assert property (@(posedge clk) disable iff (rst) (take && end_of_buffer) |=> header_pos == 6'd0)
    else $error("frame state not restarted after verdict");
  assert property (@(posedge clk) disable iff (rst) header_pos <= 6'(lfc_pkg::HdrLen))
    else $error("header position overrun");
endmodule
`default_nettype wire

// ----- hw/rtl/lfc_back.sv -----
// back end: queue of classified transactions and result sequencing
`default_nettype none
module lfc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lfc_pkg::lfc_cmd_t cmd_in,
  input  wire logic [151:0]      hdr_in,
  output logic                   full,
  output logic                   valid,
  input  wire logic              stall,
  output logic                   kind,
  output logic [7:0]             payload_byte,
  output logic [2:0]             status,
  output logic [151:0]           hdr_out,
  output logic                   last_of_run
);
  localparam int Depth = 2;
  lfc_pkg::lfc_cmd_t q [Depth];
  logic [151:0] qh [Depth];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;
  logic pay_done;
  lfc_pkg::lfc_cmd_t head;
  logic pop, emit;

  assign head = q[rd_ptr];
  assign full = count == 2'(Depth);
  assign valid = count != 2'd0 && (head.pass && !pay_done || head.verdict);
  assign kind = !(head.pass && !pay_done);
  assign payload_byte = kind ? 8'd0 : head.data;
  assign status = kind ? head.status : lfc_pkg::ST_OK;
  assign hdr_out = (kind && head.status == lfc_pkg::ST_OK) ? qh[rd_ptr] : '0;
  assign last_of_run = kind || !head.verdict;
  assign emit = valid && !stall;
  assign pop = count != 2'd0 && (!valid || (emit && last_of_run));

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
      qh[wr_ptr] <= hdr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= '0;
      pay_done <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
      if (pop) pay_done <= 1'b0;
      else if (emit) pay_done <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) pay_done |-> head.verdict)
    else $error("split transaction without verdict");
  assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("push into full queue");
endmodule
`default_nettype wire

// ----- hw/rtl/link_frame_checker_top.sv -----
// top level of the link frame checker
//
// input channel: one frame byte per transaction (data_byte) with end_of_buffer
// on the final byte; accepted when in_valid is high and in_stall low
// output channel: payload bytes (kind 0) and one verdict per frame (kind 1)
// carrying status and, when ok, the header fields; last_of_run marks the
// final result of an input transaction
// the first 36 bytes are captured as the header and produce no result unless one
// ends the buffer; later bytes pass out only if magic, header size and header
// crc were good; results wait in the back-end queue until the receiver takes them
// throughput: one byte per cycle while out_stall is low and the queue is not
// full, set by the bytewise crc update in the front end; a byte that gives both
// a payload byte and a verdict puts out the payload byte first, then the verdict,
// and stays queued until both are taken; a two-entry queue in the back end lets
// the input keep flowing while a result waits; in_stall rises only when the queue is full
// reset clears the frame state and the queue; header storage is not cleared
`default_nettype none
module link_frame_checker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [7:0]       payload_byte,
  output logic [2:0]       status,
  output logic [7:0]       version,
  output logic [15:0]      flag_bits,
  output logic [31:0]      link_seq,
  output logic [31:0]      total_size,
  output logic [31:0]      frag_offset,
  output logic [15:0]      frag_index,
  output logic [15:0]      frag_count,
  output logic             last_of_run
);
  lfc_pkg::lfc_cmd_t cmd;
  logic take, full;
  logic [151:0] hdr_f, hdr_b;

  // accepted input transaction
  assign in_stall = full;
  assign take = in_valid && !full;

  lfc_front u_front (
    .clk, .rst, .take, .data_byte, .end_of_buffer, .cmd,
    .version(hdr_f[151:144]), .flag_bits(hdr_f[143:128]), .link_seq(hdr_f[127:96]),
    .total_size(hdr_f[95:64]), .frag_offset(hdr_f[63:32]),
    .frag_index(hdr_f[31:16]), .frag_count(hdr_f[15:0])
  );

  lfc_back u_back (
    .clk, .rst, .push(take), .cmd_in(cmd), .hdr_in(hdr_f), .full,
    .valid(out_valid), .stall(out_stall), .kind, .payload_byte, .status,
    .hdr_out(hdr_b), .last_of_run
  );

  assign version = hdr_b[151:144];
  assign flag_bits = hdr_b[143:128];
  assign link_seq = hdr_b[127:96];
  assign total_size = hdr_b[95:64];
  assign frag_offset = hdr_b[63:32];
  assign frag_index = hdr_b[31:16];
  assign frag_count = hdr_b[15:0];
endmodule
`default_nettype wire

// ----- verif/link_frame_checker_top_tb.sv -----
// self-checking testbench for the link frame checker top level
`default_nettype none
module link_frame_checker_top_tb;

  // one expected or observed result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [7:0]  version;
    logic [15:0] flag_bits;
    logic [31:0] link_seq;
    logic [31:0] total_size;
    logic [31:0] frag_offset;
    logic [15:0] frag_index;
    logic [15:0] frag_count;
    logic        last_of_run;
  } frame_result_t;

  // scoreboard: a model of the deframer plus the queue of results it predicts
  class frame_scoreboard;
    int unsigned   hdr_count;
    logic [32:0]   pay_count;
    logic [7:0]    hdr_bytes [lfc_pkg::HdrLen];
    logic [31:0]   hdr_crc;
    logic [31:0]   pay_crc;
    logic          hdr_ok;
    frame_result_t pending [$];
    int unsigned   mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      hdr_count = 0;
      pay_count = '0;
      hdr_crc   = '1;
      pay_crc   = '1;
      hdr_ok    = 1'b0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
      return r;
    endfunction

    function logic [31:0] word_at(int at);
      return {hdr_bytes[at+3], hdr_bytes[at+2], hdr_bytes[at+1], hdr_bytes[at]};
    endfunction

    // note one accepted input transaction and predict what it produces
    function void note_byte(logic [7:0] b, logic eob);
      frame_result_t r;
      logic [2:0] st;
      if (hdr_count < lfc_pkg::HdrLen) begin
        hdr_bytes[hdr_count] = b;
        hdr_crc = crc_step(hdr_crc, hdr_count >= 32 ? 8'd0 : b);
        hdr_count++;
        if (hdr_count == lfc_pkg::HdrLen)
          hdr_ok = word_at(0) == lfc_pkg::FrameMagic && hdr_bytes[5] == lfc_pkg::HdrLen
                   && ~hdr_crc == word_at(32);
      end else begin
        pay_crc = crc_step(pay_crc, b);
        if (pay_count != '1) pay_count++;
        if (hdr_ok) begin
          r = '0;
          r.payload_byte = b;
          r.last_of_run = !eob;
          pending.insert(pending.size(), r);
        end
      end
      if (eob) begin
        r = '0;
        if (hdr_count < lfc_pkg::HdrLen) st = lfc_pkg::ST_SHORT;
        else if (word_at(0) != lfc_pkg::FrameMagic) st = lfc_pkg::ST_MAGIC;
        else if (hdr_bytes[5] != lfc_pkg::HdrLen) st = lfc_pkg::ST_HSIZE;
        else if (pay_count != {1'b0, word_at(20)}) st = lfc_pkg::ST_LENGTH;
        else if (~hdr_crc != word_at(32)) st = lfc_pkg::ST_HCRC;
        else if (~pay_crc != word_at(28)) st = lfc_pkg::ST_PCRC;
        else st = lfc_pkg::ST_OK;
        r.kind = 1'b1;
        r.status = st;
        if (st == lfc_pkg::ST_OK) begin
          r.version = hdr_bytes[4];
          r.flag_bits = {hdr_bytes[7], hdr_bytes[6]};
          r.link_seq = word_at(8);
          r.total_size = word_at(12);
          r.frag_offset = word_at(16);
          r.frag_index = {hdr_bytes[25], hdr_bytes[24]};
          r.frag_count = {hdr_bytes[27], hdr_bytes[26]};
        end
        r.last_of_run = 1'b1;
        pending.insert(pending.size(), r);
        restart();
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = '0;
  logic end_of_buffer = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic kind, last_of_run;
  logic [7:0] payload_byte, version;
  logic [2:0] status;
  logic [15:0] flag_bits, frag_index, frag_count;
  logic [31:0] link_seq, total_size, frag_offset;

  link_frame_checker_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  frame_scoreboard sb = new();

  // idling rates in percent, changed by the stimulus phases
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 82;
  int unsigned hold_cycles = 0;   // long receiver hold-off, counted down below
  longint unsigned cycle_count = 0;
  localparam longint unsigned CycleLimit = 400000;

  // long receiver hold-off, counted in its own process
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // receiver side: random stall, long hold-offs, and result checking
  always @(posedge clk) begin
    frame_result_t got;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      got.kind = kind;
      got.payload_byte = payload_byte;
      got.status = status;
      got.version = version;
      got.flag_bits = flag_bits;
      got.link_seq = link_seq;
      got.total_size = total_size;
      got.frag_offset = frag_offset;
      got.frag_index = frag_index;
      got.frag_count = frag_count;
      got.last_of_run = last_of_run;
      sb.check_result(got);
    end
    if (hold_cycles > 0) out_stall <= 1'b1;
    else if (rst) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // offer one byte, with random idle cycles first, until accepted
  task automatic send_byte(input logic [7:0] b, input logic eob);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_buffer <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, eob);
  endtask

  // wait until all predicted results have been seen
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  int unsigned items_sent = 0;

  // build and send a frame; bad selects a defect to inject
  // 0 good, 1 magic, 2 header size, 3 length, 4 header crc, 5 payload crc,
  // 6 short buffer, 7 random noise header
  task automatic send_frame(input int unsigned pay_len, input int unsigned bad);
    logic [7:0] hdr [lfc_pkg::HdrLen];
    logic [7:0] pay [$];
    logic [31:0] c, w;
    int unsigned cut;
    for (int i = 0; i < lfc_pkg::HdrLen; i++) hdr[i] = 8'($urandom);
    for (int i = 0; i < pay_len; i++) pay.insert(pay.size(), 8'($urandom));
    if (bad != 7) begin
      {hdr[3], hdr[2], hdr[1], hdr[0]} = lfc_pkg::FrameMagic;
      hdr[5] = 8'(lfc_pkg::HdrLen);
      c = '1;
      for (int i = 0; i < pay_len; i++) c = sb.crc_step(c, pay[i]);
      w = (bad == 5) ? ~c ^ (32'd1 << $urandom_range(31)) : ~c;
      {hdr[31], hdr[30], hdr[29], hdr[28]} = w;
      w = (bad == 3) ? pay_len + $urandom_range(1, 3) : pay_len;
      if (bad == 3 && $urandom_range(1) && pay_len > 0) w = pay_len - 1;
      {hdr[23], hdr[22], hdr[21], hdr[20]} = w;
      if (bad == 1) hdr[$urandom_range(3)] ^= 8'd1 << $urandom_range(7);
      if (bad == 2) hdr[5] = $urandom_range(1) ? 8'd37 : 8'($urandom_range(255, 37));
      c = '1;
      for (int i = 0; i < lfc_pkg::HdrLen; i++) c = sb.crc_step(c, i >= 32 ? 8'd0 : hdr[i]);
      w = (bad == 4) ? ~c ^ (32'd1 << $urandom_range(31)) : ~c;
      {hdr[35], hdr[34], hdr[33], hdr[32]} = w;
    end
    cut = (bad == 6) ? $urandom_range(lfc_pkg::HdrLen - 1) : lfc_pkg::HdrLen + pay_len - 1;
    for (int i = 0; i <= cut; i++) begin
      send_byte(i < lfc_pkg::HdrLen ? hdr[i] : pay[i - lfc_pkg::HdrLen], i == cut);
      items_sent++;
    end
  endtask

  task automatic random_frames(input int unsigned target);
    int unsigned r;
    while (items_sent < target) begin
      r = $urandom_range(99);
      send_frame($urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(6),
                 r < 65 ? 0 : $urandom_range(1, 7));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: good frames with no and one payload byte, each defect, an end
    // flag on the very first byte
    send_byte(8'hff, 1'b1);
    items_sent++;
    send_frame(0, 0);
    send_frame(1, 0);
    for (int b = 1; b <= 7; b++) send_frame(1, b);
    drain();

    // first idling phase, including a long receiver hold-off while bytes keep coming
    hold_cycles <= 200;
    send_frame(20, 0);
    random_frames(400);
    drain();

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 82;
    recv_idle_pct = 38;
    random_frames(800);
    drain();

    // full pressure, neither side idles
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(1150);
    drain();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/lfc_pkg.sv
hw/rtl/lfc_front.sv
hw/rtl/lfc_back.sv
hw/rtl/link_frame_checker_top.sv
verif/link_frame_checker_top_tb.sv
